### hw/rtl/kct_pkg.sv
`default_nettype none

package kct_pkg;

	// Fixed field widths
	localparam int unsigned KEY_W = 32;
	localparam int unsigned CNT_W = 32;

	// Request codes
	typedef enum logic {
		REQ_ADD    = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_type_t;

	// Port enables from the sequencer to the entry store
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} kct_mem_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/kct_store.sv
`default_nettype none

module kct_store import kct_pkg::*; #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned KW      = 32
) (
	input  wire logic                       clk,
	input  wire kct_mem_ctl_t               ctl,
	input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
	input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  wire logic [KW-1:0]              wr_key,
	input  wire logic [CNT_W-1:0]           wr_count,
	output logic      [KW-1:0]              rd_key,
	output logic      [CNT_W-1:0]           rd_count
);

	// Key and count held side by side, one write and one read port
	logic [KW+CNT_W-1:0] mem_q [ENTRIES];
	logic [KW+CNT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= {wr_key, wr_count};
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_key   = rd_data_q[KW+CNT_W-1:CNT_W];
	assign rd_count = rd_data_q[CNT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/kct_scan.sv
`default_nettype none

module kct_scan import kct_pkg::*; #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned KW      = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request side
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        req_type,
	input  wire logic [KW-1:0]               key_m,
	input  wire logic [CNT_W-1:0]            increment,
	// result side
	output logic                             done,
	output logic      [CNT_W-1:0]            count,
	output logic                             found,
	output logic                             dropped,
	// entry store
	output kct_mem_ctl_t                     mem_ctl,
	output logic      [$clog2(ENTRIES)-1:0]  rd_addr,
	output logic      [$clog2(ENTRIES)-1:0]  wr_addr,
	output logic      [KW-1:0]               wr_key,
	output logic      [CNT_W-1:0]            wr_count,
	input  wire logic [KW-1:0]               rd_key,
	input  wire logic [CNT_W-1:0]            rd_count
);

	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned UW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS
	} state_t;

	state_t          state_q;
	req_type_t       req_q;
	logic [KW-1:0]    key_q;
	logic [CNT_W-1:0] inc_q;
	logic [AW-1:0]    idx_q;
	logic [UW-1:0]    used_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	logic             found_q;
	logic             dropped_q;

	logic             match;
	logic             last;
	logic             has_free;
	logic [CNT_W-1:0] sum;

	// Shared compare and add on the entry just read
	assign match    = (rd_key == key_q);
	assign last     = ((UW'(idx_q) + UW'(1)) == used_q);
	assign has_free = (used_q != UW'(ENTRIES));
	assign sum      = rd_count + inc_q;

	// Store port control
	always_comb begin
		mem_ctl.rd_en = ((state_q == ST_IDLE) && start) ||
		                ((state_q == ST_SCAN) && !match && !last);
		mem_ctl.wr_en = (req_q == REQ_ADD) &&
		                (((state_q == ST_SCAN) && match) ||
		                 ((state_q == ST_MISS) && has_free));
		rd_addr  = (state_q == ST_IDLE) ? '0 : idx_q + AW'(1);
		wr_addr  = (state_q == ST_SCAN) ? idx_q : used_q[AW-1:0];
		wr_key   = key_q;
		wr_count = (state_q == ST_SCAN) ? sum : inc_q;
	end

	// Sequencer: capture, scan valid entries one per cycle, resolve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			req_q     <= REQ_ADD;
			key_q     <= '0;
			inc_q     <= '0;
			idx_q     <= '0;
			used_q    <= '0;
			done_q    <= 1'b0;
			count_q   <= '0;
			found_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req_type_t'(req_type);
						key_q   <= key_m;
						inc_q   <= increment;
						idx_q   <= '0;
						state_q <= (used_q == '0) ? ST_MISS : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						done_q    <= 1'b1;
						found_q   <= 1'b1;
						dropped_q <= 1'b0;
						count_q   <= (req_q == REQ_ADD) ? sum : rd_count;
						state_q   <= ST_IDLE;
					end else if (last) begin
						state_q <= ST_MISS;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_MISS: begin
					done_q  <= 1'b1;
					found_q <= 1'b0;
					state_q <= ST_IDLE;
					if (req_q == REQ_ADD && has_free) begin
						count_q   <= inc_q;
						dropped_q <= 1'b0;
						used_q    <= used_q + UW'(1);
					end else if (req_q == REQ_ADD) begin
						count_q   <= '0;
						dropped_q <= 1'b1;
					end else begin
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign count   = count_q;
	assign found   = found_q;
	assign dropped = dropped_q;

endmodule

`default_nettype wire

### hw/rtl/key_count_table.sv
// A request is accepted at start && !busy; its result comes on done once the scan reaches
// a hit at entry i, or once all entries in use are scanned and the miss state resolves it.
// The scan reads one key per cycle through the single read port of the entry store; a new
// request is taken only after the last one is done, and busy is low again in the done cycle.
// The receiver cannot stall: done is high for a single cycle; count, found and dropped hold.
// Reset (arst_n low) empties the table at once; no clearing pass is needed.
`default_nettype none

module key_count_table import kct_pkg::*; #(
	parameter int unsigned ENTRIES  = 64,
	parameter int unsigned KEY_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    req_type,
	input  wire logic        [KEY_W-1:0] key,
	input  wire logic signed [CNT_W-1:0] increment,
	output logic                         done,
	output logic signed      [CNT_W-1:0] count,
	output logic                         found,
	output logic                         dropped
);

	// Stored key width: keys are masked to KEY_BITS, never wider than the port
	localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int unsigned AW = $clog2(ENTRIES);

	kct_mem_ctl_t     mem_ctl;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [KW-1:0]    wr_key;
	logic [CNT_W-1:0] wr_count;
	logic [KW-1:0]    rd_key;
	logic [CNT_W-1:0] rd_count;
	logic [CNT_W-1:0] count_u;

	kct_scan #(
		.ENTRIES (ENTRIES),
		.KW      (KW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.key_m     (key[KW-1:0]),
		.increment (CNT_W'(increment)),
		.done      (done),
		.count     (count_u),
		.found     (found),
		.dropped   (dropped),
		.mem_ctl   (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_count  (wr_count),
		.rd_key    (rd_key),
		.rd_count  (rd_count)
	);

	kct_store #(
		.ENTRIES (ENTRIES),
		.KW      (KW)
	) u_store (
		.clk      (clk),
		.ctl      (mem_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_count (wr_count),
		.rd_key   (rd_key),
		.rd_count (rd_count)
	);

	assign count = signed'(count_u);

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import kct_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int TABLE_DEPTH = 64;
	localparam int SCRIPT_LEN  = 16;

	// One result as the block reports it
	typedef struct packed {
		logic signed [CNT_W-1:0] cnt;
		logic                    hit;
		logic                    drop;
	} count_result_t;

	// One row of the directed script; want is used only where typed is set
	typedef struct packed {
		req_type_t               kind;
		logic        [KEY_W-1:0] k;
		logic signed [CNT_W-1:0] inc;
		logic                    typed;
		count_result_t           want;
	} script_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	req_type_t               req_type = REQ_ADD;
	logic        [KEY_W-1:0] key = '0;
	logic signed [CNT_W-1:0] increment = '0;
	logic                    done;
	logic signed [CNT_W-1:0] count;
	logic                    found;
	logic                    dropped;

	// Shadow copy of the table, filled from index 0 upwards
	logic        [KEY_W-1:0] tbl_key [TABLE_DEPTH];
	logic signed [CNT_W-1:0] tbl_cnt [TABLE_DEPTH];
	int                      tbl_used = 0;

	count_result_t awaited_counts[$];
	int            mismatches = 0;
	int            send_idle_pct = 0;

	// Directed rows: reset state, extremes of key and increment, wrap-around
	script_row_t script [SCRIPT_LEN] = '{
		'{REQ_LOOKUP, 32'h0000_0000, 32'sh0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 1'b0}},
		'{REQ_ADD,    32'h0000_0000, 32'sh7FFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 1'b0, 1'b0}},
		'{REQ_ADD,    32'h0000_0000, 32'sh0000_0001, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
		'{REQ_ADD,    32'hFFFF_FFFF, 32'sh8000_0000, 1'b1, '{32'sh8000_0000, 1'b0, 1'b0}},
		'{REQ_ADD,    32'hFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
		'{REQ_LOOKUP, 32'hFFFF_FFFF, 32'sh1234_5678, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0}},
		'{REQ_LOOKUP, 32'h0000_0001, 32'sh0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 1'b0}},
		'{REQ_ADD,    32'h0000_0000, 32'sh0000_0000, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
		'{REQ_ADD,    32'h8000_0000, 32'sh0000_0000, 1'b1, '{32'sh0000_0000, 1'b0, 1'b0}},
		'{REQ_ADD,    32'h0000_0001, 32'sh5555_5555, 1'b0, '0},
		'{REQ_ADD,    32'hAAAA_AAAA, 32'shAAAA_AAAA, 1'b0, '0},
		'{REQ_ADD,    32'h0000_0001, 32'shAAAA_AAAB, 1'b0, '0},
		'{REQ_LOOKUP, 32'hAAAA_AAAA, 32'shFFFF_FFFF, 1'b0, '0},
		'{REQ_LOOKUP, 32'h8000_0000, 32'sh0000_0000, 1'b0, '0},
		'{REQ_ADD,    32'h7FFF_FFFF, 32'shFFFF_FFFB, 1'b0, '0},
		'{REQ_LOOKUP, 32'h7FFF_FFFE, 32'sh7FFF_FFFF, 1'b1, '{32'sh0000_0000, 1'b0, 1'b0}}
	};

	key_count_table #(
		.ENTRIES (TABLE_DEPTH),
		.KEY_BITS(KEY_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.key      (key),
		.increment(increment),
		.done     (done),
		.count    (count),
		.found    (found),
		.dropped  (dropped)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hang guard
	initial begin
		#(CLK_PERIOD * 1_000_000);
		$display("Regression FAIL");
		$finish;
	end

	// Applies one request to the shadow table and returns what the block should report
	function automatic count_result_t tally_request(input req_type_t kind,
			input logic [KEY_W-1:0] k, input logic signed [CNT_W-1:0] inc);
		count_result_t r;
		int slot;
		r = '0;
		slot = -1;
		for (int i = 0; i < tbl_used; i++) begin
			if (slot < 0 && tbl_key[i] == k)
				slot = i;
		end
		if (kind == REQ_ADD) begin
			if (slot >= 0) begin
				tbl_cnt[slot] = tbl_cnt[slot] + inc;
				r.cnt = tbl_cnt[slot];
				r.hit = 1'b1;
			end else if (tbl_used < TABLE_DEPTH) begin
				tbl_key[tbl_used] = k;
				tbl_cnt[tbl_used] = inc;
				tbl_used++;
				r.cnt = inc;
			end else begin
				r.drop = 1'b1;
			end
		end else if (slot >= 0) begin
			r.cnt = tbl_cnt[slot];
			r.hit = 1'b1;
		end
		return r;
	endfunction

	// Presents one request, holds it until taken, then logs what it should give
	task automatic issue_request(input req_type_t kind, input logic [KEY_W-1:0] k,
			input logic signed [CNT_W-1:0] inc, input logic typed, input count_result_t want);
		count_result_t predicted;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		start     <= 1'b1;
		req_type  <= kind;
		key       <= k;
		increment <= inc;
		do @(posedge clk); while (busy);
		predicted = tally_request(kind, k, inc);
		awaited_counts.push_back(typed ? want : predicted);
	endtask

	// Sender holds off until every outstanding request has reported
	task automatic drain_requests();
		start <= 1'b0;
		while (awaited_counts.size() != 0)
			@(posedge clk);
	endtask

	// Mostly keys already in the table, some fresh ones that claim entries or get dropped
	task automatic random_requests(input int n_items);
		req_type_t               kind;
		logic        [KEY_W-1:0] k;
		logic signed [CNT_W-1:0] inc;
		for (int n = 0; n < n_items; n++) begin
			kind = ($urandom_range(99) < 25) ? REQ_LOOKUP : REQ_ADD;
			if (tbl_used > 0 && $urandom_range(99) < 85)
				k = tbl_key[$urandom_range(tbl_used - 1)];
			else
				k = $urandom;
			case ($urandom_range(3))
				0: inc = $signed($urandom_range(20)) - 10;
				1: begin
					case ($urandom_range(2))
						0: inc = 32'sh7FFF_FFFF;
						1: inc = 32'sh8000_0000;
						default: inc = 32'shFFFF_FFFF;
					endcase
				end
				default: inc = $urandom;
			endcase
			issue_request(kind, k, inc, 1'b0, '0);
		end
	endtask

	// Result check against the oldest outstanding request
	always @(posedge clk) begin : check_results
		count_result_t want;
		if (arst_n && done) begin
			if (awaited_counts.size() == 0) begin
				$display("%0t: unexpected result count %0d found %0b dropped %0b",
					$time, count, found, dropped);
				mismatches++;
			end else begin
				want = awaited_counts.pop_front();
				if (count !== want.cnt) begin
					$display("%0t: count expected %0d actual %0d", $time, want.cnt, count);
					mismatches++;
				end
				if (found !== want.hit) begin
					$display("%0t: found expected %0b actual %0b", $time, want.hit, found);
					mismatches++;
				end
				if (dropped !== want.drop) begin
					$display("%0t: dropped expected %0b actual %0b", $time, want.drop, dropped);
					mismatches++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script, back to back
		for (int i = 0; i < SCRIPT_LEN; i++)
			issue_request(script[i].kind, script[i].k, script[i].inc, script[i].typed,
				script[i].want);
		drain_requests();

		// Random phases: light sender gaps, heavy gaps, then none
		send_idle_pct = 23;
		random_requests(433);
		drain_requests();
		send_idle_pct = 70;
		random_requests(433);
		drain_requests();
		send_idle_pct = 0;
		random_requests(434);
		drain_requests();

		// Room for any stray result after the last one
		repeat (TABLE_DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
hw/rtl/kct_pkg.sv
hw/rtl/kct_store.sv
hw/rtl/kct_scan.sv
hw/rtl/key_count_table.sv
bench/tb_top.sv
